/* design/hex_color_string_parser_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the hex color string parser
// Shared concurrent assertion shorthands, clocked on clk_i and disabled
// while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef HEX_COLOR_STRING_PARSER_MACROS_SVH
`define HEX_COLOR_STRING_PARSER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define HCSP_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define HCSP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hcsp_pkg.sv */
// ---------------------------------------------------------------------------
// Hex color string parser package
// Types and constants shared by the parser modules.
// ---------------------------------------------------------------------------
package hcsp_pkg;

  // Transaction kind on the input channel.
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_e;

  // Where the parser stands within the string.
  typedef enum logic [1:0] {
    PH_LEAD    = 2'd0,
    PH_ZERO    = 2'd1,
    PH_AFTER_X = 2'd2,
    PH_BODY    = 2'd3
  } phase_e;

  // Result status.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_DIGIT = 2'd3
  } status_e;

  localparam logic [3:0] CountSat    = 4'd9;
  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] HashChar    = 8'h23;

  // Parser state as seen by the result formatter at an end marker.
  typedef struct packed {
    phase_e      phase;
    logic [31:0] nibbles;
    logic [3:0]  count;
    logic        bad;
  } snap_t;

endpackage

/* design/hcsp_if.sv */
// ---------------------------------------------------------------------------
// Hex color string parser channels
// Valid/ready channels for characters in and color results out.
// ---------------------------------------------------------------------------
interface hcsp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] character;

  modport source (output valid, output opcode, output character, input ready);
  modport sink   (input valid, input opcode, input character, output ready);
endinterface

interface hcsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       alpha_present;
  logic [1:0] status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output alpha_present, output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input alpha_present, input status, output ready);
endinterface

/* design/hex_color_string_parser.sv */
// ---------------------------------------------------------------------------
// Hex color string parser
// Parses a streamed CSS-style hex color string into RGBA bytes and a status.
// ---------------------------------------------------------------------------
// Usage: the input channel carries one transaction per character (opcode 0)
// and a final transaction with opcode 1 that marks the end of the string.
// Character transactions produce no output. Each end marker produces exactly
// one output transaction with red, green, blue, alpha, alpha_present and a
// status (ok, empty, bad length or bad digit), after which the parser is
// ready for the next string.
// Throughput is one input transaction per cycle, character or end marker,
// while no end marker waits for a stalled output. An accepted end marker
// waits in the input register while the formatting logic reads the parse
// state, and the output register captures the result once it is free or
// being drained.
// Reset clears the parse state and both valid flags; the block then accepts
// input immediately. When the receiver stalls, the result stays in the
// output register. Characters keep flowing; a second end marker waits in the
// input register, and input ready drops only while it waits.
// ---------------------------------------------------------------------------
module hex_color_string_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcsp_in_if.sink     in_i,
  hcsp_out_if.source  out_o
);
  import hcsp_pkg::*;

  // Input register: holds one accepted transaction for the parse stage.
  logic       in_valid_q, in_valid_d;
  op_e        in_op_q;
  logic [7:0] in_char_q;

  logic       can_load;
  logic       advance;
  logic       accept;
  snap_t      snap;

  // A character always retires without waiting, since it only updates state.
  // An end marker retires when the output register is free or being drained.
  assign advance = in_valid_q && ((in_op_q == OP_CHAR) || can_load);
  assign in_i.ready = !in_valid_q || advance;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= op_e'(in_i.opcode);
      in_char_q <= in_i.character;
    end
  end

  // Parse state: consumes one character per cycle while no end marker waits, resets at the end marker.
  hcsp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .op_i   (in_op_q),
    .char_i (in_char_q),
    .snap_o (snap)
  );

  // Result stage: formats the state seen at the end marker and registers it.
  hcsp_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && (in_op_q == OP_END)),
    .snap_i     (snap),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

/* design/hcsp_parse.sv */
// ---------------------------------------------------------------------------
// Hex color string parser state
// Holds the per-string parse state and updates it by one character per cycle with step_i set.
// ---------------------------------------------------------------------------
`include "hex_color_string_parser_macros.svh"

module hcsp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  hcsp_pkg::op_e op_i,
  input  logic [7:0]    char_i,
  output hcsp_pkg::snap_t snap_o
);
  import hcsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] store_q, store_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  pend_q, pend_d;
  logic        bad_q, bad_d;

  logic       is_ws;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [4:0] push_n;
  logic [4:0] total;
  logic [6:0] shift_amt;
  logic       is_x;

  // C-locale whitespace: space, tab, LF, VT, FF, CR.
  assign is_ws = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0D);
  assign is_x  = (char_i == 8'h78) || (char_i == 8'h58);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = char_i[3:0];
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      hex_val = char_i[3:0];
    end else if ((char_i >= 8'h61 && char_i <= 8'h66) ||
                 (char_i >= 8'h41 && char_i <= 8'h46)) begin
      hex_val = char_i[3:0] + 4'd9;
    end else begin
      is_hex  = 1'b0;
      hex_val = 4'd0;
    end
  end

  // Deferred whitespace becomes zero nibbles once another character follows,
  // so a body character pushes the pending count plus one nibbles at once.
  assign push_n    = {1'b0, pend_q} + 5'd1;
  assign total     = {1'b0, cnt_q} + push_n;
  assign shift_amt = {push_n, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      store_q <= '0;
      cnt_q   <= '0;
      pend_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      store_q <= store_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      bad_q   <= bad_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    store_d = store_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    bad_d   = bad_q;
    if (step_i) begin
      if (op_i == OP_END) begin
        phase_d = PH_LEAD;
        store_d = '0;
        cnt_d   = '0;
        pend_d  = '0;
        bad_d   = 1'b0;
      end else begin
        logic take_body;
        take_body = 1'b0;
        case (phase_q)
          PH_LEAD: begin
            if (is_ws) begin
              take_body = 1'b0;
            end else if (char_i == 8'h30) begin
              phase_d = PH_ZERO;
              store_d = '0;
              cnt_d   = 4'd1;
            end else if (char_i == HashChar) begin
              phase_d = PH_BODY;
            end else begin
              take_body = 1'b1;
            end
          end
          PH_ZERO: begin
            if (is_x) begin
              phase_d = PH_AFTER_X;
              store_d = '0;
              cnt_d   = '0;
            end else begin
              take_body = 1'b1;
            end
          end
          PH_AFTER_X: begin
            if (char_i == HashChar) begin
              phase_d = PH_BODY;
            end else begin
              take_body = 1'b1;
            end
          end
          default: begin
            take_body = 1'b1;
          end
        endcase
        if (take_body) begin
          phase_d = PH_BODY;
          if (is_ws) begin
            pend_d = (pend_q < CountSat) ? pend_q + 4'd1 : pend_q;
          end else begin
            pend_d = '0;
            bad_d  = bad_q | (pend_q != 4'd0) | ~is_hex;
            cnt_d  = (total > {1'b0, CountSat}) ? CountSat : total[3:0];
            // Past eight nibbles the count alone decides the result.
            if (total <= 5'd8) begin
              store_d = (store_q << shift_amt) | {28'd0, hex_val};
            end
          end
        end
      end
    end
  end

  assign snap_o = '{phase: phase_q, nibbles: store_q, count: cnt_q, bad: bad_q};

  `HCSP_ASSERT(a_count_sat, (cnt_q <= CountSat) && (pend_q <= CountSat), "count overflow")
  `HCSP_ASSERT_IMPL(a_lead_clean, phase_q == PH_LEAD,
    (cnt_q == 4'd0) && (pend_q == 4'd0) && !bad_q, "dirty state in leading phase")
  `HCSP_ASSERT_NEXT(a_end_resets, step_i && (op_i == OP_END),
    (phase_q == PH_LEAD) && (cnt_q == 4'd0), "state not reset after end marker")

endmodule

/* design/hcsp_out.sv */
// ---------------------------------------------------------------------------
// Hex color string parser result stage
// Turns the parse state at an end marker into RGBA bytes and a status and
// holds them in the output register.
// ---------------------------------------------------------------------------
`include "hex_color_string_parser_macros.svh"

module hcsp_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  hcsp_pkg::snap_t snap_i,
  output logic            can_load_o,
  hcsp_out_if.source      out_o
);
  import hcsp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] red_q, green_q, blue_q, alpha_q;
  logic       ap_q;
  status_e    status_q;

  logic [7:0] red_d, green_d, blue_d, alpha_d;
  logic       ap_d;
  status_e    status_d;
  logic       len_ok;
  logic [3:0] n;
  logic [31:0] s;

  assign n = snap_i.count;
  assign s = snap_i.nibbles;
  assign len_ok = (n == 4'd3) || (n == 4'd4) || (n == 4'd6) || (n == 4'd8);

  // Short forms repeat a nibble into both halves of a byte, i.e. times 17.
  always_comb begin
    red_d    = '0;
    green_d  = '0;
    blue_d   = '0;
    alpha_d  = '0;
    ap_d     = 1'b0;
    status_d = ST_OK;
    if (snap_i.phase == PH_LEAD) begin
      status_d = ST_EMPTY;
    end else if (!len_ok) begin
      status_d = ST_BAD_LEN;
    end else begin
      ap_d = (n == 4'd4) || (n == 4'd8);
      if (snap_i.bad) begin
        status_d = ST_BAD_DIGIT;
      end else begin
        case (n)
          4'd3: begin
            red_d   = {s[11:8], s[11:8]};
            green_d = {s[7:4], s[7:4]};
            blue_d  = {s[3:0], s[3:0]};
            alpha_d = AlphaOpaque;
          end
          4'd4: begin
            red_d   = {s[15:12], s[15:12]};
            green_d = {s[11:8], s[11:8]};
            blue_d  = {s[7:4], s[7:4]};
            alpha_d = {s[3:0], s[3:0]};
          end
          4'd6: begin
            red_d   = s[23:16];
            green_d = s[15:8];
            blue_d  = s[7:0];
            alpha_d = AlphaOpaque;
          end
          default: begin
            red_d   = s[31:24];
            green_d = s[23:16];
            blue_d  = s[15:8];
            alpha_d = s[7:0];
          end
        endcase
      end
    end
  end

  assign can_load_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      alpha_q  <= alpha_d;
      ap_q     <= ap_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.red           = red_q;
  assign out_o.green         = green_q;
  assign out_o.blue          = blue_q;
  assign out_o.alpha         = alpha_q;
  assign out_o.alpha_present = ap_q;
  assign out_o.status        = status_q;

  `HCSP_ASSERT_IMPL(a_err_zero, valid_q && (status_q != ST_OK),
    (red_q == 8'd0) && (green_q == 8'd0) && (blue_q == 8'd0) && (alpha_q == 8'd0),
    "color bytes not cleared on error")
  `HCSP_ASSERT_IMPL(a_no_alpha_flag, valid_q && (status_q == ST_EMPTY || status_q == ST_BAD_LEN),
    !ap_q, "alpha flag set without a valid length")
  `HCSP_ASSERT_IMPL(a_opaque_default, valid_q && (status_q == ST_OK) && !ap_q,
    alpha_q == AlphaOpaque, "alpha not opaque without alpha digits")

endmodule

/* tb/tb_hex_color_string_parser.sv */
// ---------------------------------------------------------------------------
// Hex color string parser testbench
// Streams color strings into the parser one character per transaction, each
// string closed by an end marker. A parser model inside a small tracker
// class predicts the color and status of every string. Each output
// transaction is checked field by field against the oldest prediction.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_hex_color_string_parser;
  import hcsp_pkg::*;

  // One color result as it appears on the output channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       alpha_present;
    status_e    status;
  } color_t;

  typedef logic [7:0] char_q_t[$];

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned TargetItems = 400;
  localparam int unsigned DrainCycles = 10;

  // Parser model: follows every accepted input transaction and queues the
  // color that each end marker must produce.
  class color_tracker;
    phase_e      phase;
    logic [31:0] nibbles;
    logic [3:0]  count;
    logic [3:0]  spaces;
    bit          bad;
    color_t      pending_colors[$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      phase   = PH_LEAD;
      nibbles = '0;
      count   = '0;
      spaces  = '0;
      bad     = 1'b0;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void push_nibble(logic [3:0] v);
      if (count < 4'd8) nibbles = {nibbles[27:0], v};
      if (count < CountSat) count++;
    endfunction

    // A body character. Whitespace is held back; it only becomes part of
    // the body (as bad digits) when something else follows it.
    function void body_char(logic [7:0] c);
      int v;
      phase = PH_BODY;
      if (is_space(c)) begin
        if (spaces < CountSat) spaces++;
        return;
      end
      while (spaces != 0) begin
        push_nibble(4'd0);
        bad = 1'b1;
        spaces--;
      end
      v = hex_value(c);
      if (v < 0) begin
        bad = 1'b1;
        push_nibble(4'd0);
      end else begin
        push_nibble(v[3:0]);
      end
    endfunction

    function logic [3:0] nibble_at(int pos, int n);
      return 4'(nibbles >> (4 * (n - 1 - pos)));
    endfunction

    function void observe_input(op_e op, logic [7:0] c);
      color_t col;
      int     n;
      if (op == OP_CHAR) begin
        case (phase)
          PH_LEAD: begin
            if (!is_space(c)) begin
              if (c == "0") begin
                push_nibble(4'd0);
                phase = PH_ZERO;
              end else if (c == HashChar) begin
                phase = PH_BODY;
              end else begin
                body_char(c);
              end
            end
          end
          PH_ZERO: begin
            if (c == "x" || c == "X") begin
              nibbles = '0;
              count   = '0;
              phase   = PH_AFTER_X;
            end else begin
              body_char(c);
            end
          end
          PH_AFTER_X: begin
            if (c == HashChar) phase = PH_BODY;
            else body_char(c);
          end
          default: body_char(c);
        endcase
        return;
      end
      col = '0;
      n   = count;
      if (phase == PH_LEAD) begin
        col.status = ST_EMPTY;
      end else if (!(n == 3 || n == 4 || n == 6 || n == 8)) begin
        col.status = ST_BAD_LEN;
      end else begin
        col.alpha_present = (n == 4 || n == 8);
        if (bad) begin
          col.status = ST_BAD_DIGIT;
        end else begin
          col.status = ST_OK;
          if (n <= 4) begin
            col.red   = nibble_at(0, n) * 8'd17;
            col.green = nibble_at(1, n) * 8'd17;
            col.blue  = nibble_at(2, n) * 8'd17;
            col.alpha = (n == 4) ? nibble_at(3, n) * 8'd17 : AlphaOpaque;
          end else begin
            col.red   = {nibble_at(0, n), nibble_at(1, n)};
            col.green = {nibble_at(2, n), nibble_at(3, n)};
            col.blue  = {nibble_at(4, n), nibble_at(5, n)};
            col.alpha = (n == 8) ? {nibble_at(6, n), nibble_at(7, n)} : AlphaOpaque;
          end
        end
      end
      pending_colors.push_back(col);
      clear();
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (pending_colors.size() == 0) begin
        $error("color result with no end marker waiting: status %0d", got.status);
        mismatch_count++;
        return;
      end
      want = pending_colors.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("alpha_present", want.alpha_present, got.alpha_present);
      compare_field("status", want.status, got.status);
    endfunction

    function int outstanding();
      return pending_colors.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hcsp_in_if  in_if ();
  hcsp_out_if out_if ();

  hex_color_string_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  color_tracker tracker = new();
  int unsigned  chars_sent;
  int unsigned  strings_sent;
  int unsigned  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Idle length for either side: mostly none or short, at times a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0a;
      3: return 8'h0b;
      4: return 8'h0c;
      default: return 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  // Monitor and watchdog. Both channels are sampled at the clock edge, so
  // every value seen here is the one the parser saw at that edge. The
  // watchdog counts cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        tracker.observe_input(op_e'(in_if.opcode), in_if.character);
      end
      if (out_if.valid && out_if.ready) begin
        tracker.check_color('{out_if.red, out_if.green, out_if.blue, out_if.alpha,
                              out_if.alpha_present, status_e'(out_if.status)});
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("** hex_color_string_parser: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result receiver: random stalls of mixed length, with long stretches in
  // which it takes every result at once.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b0;
        repeat (1 + pause_len()) @(posedge clk_i);
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  // Drives one transaction and returns at the edge that accepts it. When
  // there is no gap, valid simply stays high with the new payload.
  task automatic send_item(input op_e op, input logic [7:0] c, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : pause_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.character <= c;
    do @(posedge clk_i); while (!in_if.ready);
    if (op == OP_CHAR) chars_sent++;
  endtask

  // Sends a whole string and its end marker; the character byte of the end
  // marker is random since the parser must ignore it.
  task automatic send_string(input char_q_t s);
    bit calm;
    calm = ($urandom_range(0, 4) == 0);
    foreach (s[i]) send_item(OP_CHAR, s[i], calm);
    send_item(OP_END, 8'($urandom), calm);
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    char_q_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_string(s);
  endtask

  // The sender stops until every predicted color has come back.
  task automatic drain_colors();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // Random string. Most are well formed with random content; the rest have
  // a wrong digit count, a corrupted or split body, pure noise, or a long
  // run of whitespace after the body.
  task automatic make_string(output char_q_t s);
    char_q_t     body;
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    int          lens[4] = '{3, 4, 6, 8};
    kind = $urandom_range(0, 99);
    s = {};
    if (kind >= 88 && kind < 95) begin
      repeat ($urandom_range(0, 12)) s.push_back(8'($urandom));
      return;
    end
    len = (kind >= 60 && kind < 75) ? $urandom_range(0, 12) : lens[$urandom_range(0, 3)];
    repeat (len) body.push_back(hex_char());
    if (kind >= 75 && kind < 88) begin
      pos = $urandom_range(0, len - 1);
      body[pos] = $urandom_range(0, 1) ? space_char() : 8'($urandom);
    end
    repeat ($urandom_range(0, 3)) s.push_back(space_char());
    case ($urandom_range(0, 4))
      1: begin s.push_back("0"); s.push_back("x"); end
      2: begin s.push_back("0"); s.push_back("X"); end
      3: s.push_back(HashChar);
      4: begin s.push_back("0"); s.push_back("x"); s.push_back(HashChar); end
      default: ;
    endcase
    foreach (body[i]) s.push_back(body[i]);
    if (kind >= 95) begin
      repeat ($urandom_range(10, 12)) s.push_back(space_char());
      if ($urandom_range(0, 1)) s.push_back(hex_char());
    end else begin
      repeat ($urandom_range(0, 3)) s.push_back(space_char());
    end
  endtask

  initial begin
    char_q_t s;
    chars_sent      = 0;
    strings_sent    = 0;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.opcode    <= OP_CHAR;
    in_if.character <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: trimming, every prefix form, every status, short
    // and long forms at their extremes, inner whitespace, saturation of the
    // digit and whitespace counts.
    send_text("");
    send_text(" \t\n\v\f\r ");
    send_text("#FFF");
    send_text("#000");
    send_text("0x12345678");
    send_text("0XaBcDeF");
    send_text("  #0f0a \t");
    send_text("#ffffffff");
    send_text("0x#abc");
    send_text("0x");
    send_text("#");
    send_text("0");
    send_text("00FF00");
    send_text("12 34 56");
    send_text("#12g");
    send_text("#12g45");
    send_text("#1234567890");
    send_text("#  abc");
    send_text("#1            2");
    s = {HashChar, 8'h00, 8'hff, 8'h80};
    send_string(s);
    send_text("x12");
    drain_colors();

    // Every character and every end marker counts toward the item budget.
    while (chars_sent + strings_sent < TargetItems) begin
      if (strings_sent % 25 == 0) drain_colors();
      make_string(s);
      send_string(s);
    end
    drain_colors();
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("** hex_color_string_parser: PASSED **");
    end else begin
      $display("** hex_color_string_parser: FAILED **");
    end
    $finish;
  end

endmodule
